FILE: hdl/tbc_pkg.sv
package tbc_pkg;

   localparam int REQ_W = 288;
   localparam int RSP_W = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOT_THR  = 2'd3;

   // squared raw normal length at or below this: length under 0.0001
   localparam logic [61:0] EPS_SQ_MAX = 62'd184467440737;
   localparam logic [16:0] Q_ONE = 17'd65536;

   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS = 16;

   typedef struct packed {
      logic               degen;
      logic signed [63:0] num;
   } sq_side_type;

   typedef struct packed {
      logic [61:0] x;
      logic [33:0] rem;
      logic [30:0] root;
   } sqrt_lane_type;

   typedef struct packed {
      logic [61:0] den;
      logic [62:0] r;
      logic [15:0] q;
      logic        sat;
      logic        zero;
      logic        neg;
      logic        degen;
   } div_state_type;

   typedef struct packed {
      logic signed [17:0] facing_dot;
      logic               degenerate;
      logic               cull;
   } rsp_type;

endpackage

FILE: hdl/triangle_backface_cull_core.sv
// Channel  Direction  Handshake                Content
// req      in         req_tvalid/req_tready    triangle, nine Q16.16 coordinates
// rsp      out        rsp_tvalid/rsp_tready    cull, degenerate, facing_dot
// csr      in         csr_valid/csr_ready      register index and write data
//
// One triangle per cycle while req_tready is high; each result passes the front end,
// the 31-stage square root pipeline, the 16 divider step stages and the output register.
// Reset clears all valid bits and the camera and threshold registers to zero.
// A stalled rsp holds; one skid entry absorbs the item in flight, then req_tready drops
// and the whole pipeline freezes until the skid entry drains.
module triangle_backface_cull_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z, 32 bits each
   input  logic [tbc_pkg::REQ_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cull [0], degenerate [1], facing_dot [19:2], zero [23:20]
   output logic [tbc_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data
);

   logic signed [31:0]   cam_ff [3];
   logic signed [17:0]   thr_ff;
   logic                 en;
   logic                 f_valid, s_valid, d_valid, d_degen;
   logic [61:0]          n2, w2;
   logic [30:0]          ln, lw;
   tbc_pkg::sq_side_type f_side, s_side;
   logic signed [17:0]   d_dot;
   tbc_pkg::rsp_type     res_in, out_ff, skid_ff;
   logic                 out_v_ff, skid_v_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff[0] <= '0;
         cam_ff[1] <= '0;
         cam_ff[2] <= '0;
         thr_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            tbc_pkg::CSR_CAMERA_X: cam_ff[0] <= csr_data;
            tbc_pkg::CSR_CAMERA_Y: cam_ff[1] <= csr_data;
            tbc_pkg::CSR_CAMERA_Z: cam_ff[2] <= csr_data;
            tbc_pkg::CSR_DOT_THR:  thr_ff    <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   assign en         = !skid_v_ff;
   assign req_tready = en;

   tbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .cam       (cam_ff),
      .out_valid (f_valid),
      .n2        (n2),
      .w2        (w2),
      .side      (f_side)
   );

   tbc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .rad_a     (n2),
      .rad_b     (w2),
      .in_side   (f_side),
      .out_valid (s_valid),
      .root_a    (ln),
      .root_b    (lw),
      .out_side  (s_side)
   );

   tbc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .len_n     (ln),
      .len_w     (lw),
      .in_side   (s_side),
      .out_valid (d_valid),
      .dot       (d_dot),
      .degen     (d_degen)
   );

   always_comb begin
      res_in.facing_dot = d_dot;
      res_in.degenerate = d_degen;
      res_in.cull       = d_degen || (d_dot > thr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_tready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (d_valid) begin
         if (!out_v_ff || rsp_tready) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_tready) begin
            out_ff <= skid_ff;
         end
      end else if (d_valid) begin
         if (!out_v_ff || rsp_tready) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0000, out_ff};

endmodule

FILE: hdl/tbc_front.sv
module tbc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [tbc_pkg::REQ_W-1:0]   in_data,
   input  logic signed [31:0]          cam [3],
   output logic                        out_valid,
   output logic [61:0]                 n2,
   output logic [61:0]                 w2,
   output tbc_pkg::sq_side_type        side
);

   function automatic logic signed [31:0] edge_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      if (d[32] != d[31]) begin
         return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return d[31:0];
   endfunction

   function automatic logic signed [34:0] view3(input logic signed [31:0] c,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic signed [31:0] d);
      logic signed [34:0] cc;
      cc = 35'(c);
      return (cc <<< 1) + cc - (35'(a) + 35'(b) + 35'(d));
   endfunction

   function automatic logic [62:0] mag63(input logic signed [63:0] n);
      logic signed [63:0] m;
      m = -n;
      return n[63] ? m[62:0] : n[62:0];
   endfunction

   function automatic logic [33:0] mag34(input logic signed [34:0] n);
      logic signed [34:0] m;
      m = -n;
      return n[34] ? m[33:0] : n[33:0];
   endfunction

   // smallest s with m >> s below 2^30
   function automatic logic [5:0] shift_of(input logic [62:0] m);
      logic [5:0] s;
      s = '0;
      for (int i = 30; i < 63; i++) begin
         if (m[i]) s = 6'(i - 29);
      end
      return s;
   endfunction

   logic [7:0] v_ff;
   logic [7:0] v_in;

   logic signed [31:0] e1_in [3], e2_in [3], e1_ff [3], e2_ff [3];
   logic signed [34:0] w1_in [3], w1_ff [3], wv2_ff [3], wv3_ff [3];
   logic signed [63:0] pa_in [3], pb_in [3], pa_ff [3], pb_ff [3];
   logic signed [63:0] n3_ff [3];
   logic [62:0] nm4_in [3], nm4_ff [3], nm5_ff [3];
   logic [33:0] wm4_in [3], wm4_ff [3], wm5_ff [3];
   logic [2:0]  nsg4_ff, wsg4_ff, nsg5_ff, wsg5_ff, nsg6_ff, wsg6_ff, psg7_ff;
   logic [5:0]  nsh5_in, wsh5_in, nsh5_ff, wsh5_ff;
   logic [29:0] nsm6_in [3], wsm6_in [3], nsm6_ff [3], wsm6_ff [3];
   logic        nz6_ff, nz7_ff;
   logic [59:0] nsq7_ff [3], wsq7_ff [3], pr7_ff [3];
   logic [61:0] n2_in, w2_in, n2_ff, w2_ff;
   logic signed [63:0] num_in, num_ff;
   logic        degen_in, degen_ff;

   assign v_in = {v_ff[6:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = edge_sat($signed(in_data[(3 + i) * 32 +: 32]),
                             $signed(in_data[i * 32 +: 32]));
         e2_in[i] = edge_sat($signed(in_data[(6 + i) * 32 +: 32]),
                             $signed(in_data[i * 32 +: 32]));
         w1_in[i] = view3(cam[i], $signed(in_data[i * 32 +: 32]),
                          $signed(in_data[(3 + i) * 32 +: 32]),
                          $signed(in_data[(6 + i) * 32 +: 32]));
      end
   end

   always_comb begin
      pa_in[0] = e1_ff[1] * e2_ff[2];
      pb_in[0] = e1_ff[2] * e2_ff[1];
      pa_in[1] = e1_ff[2] * e2_ff[0];
      pb_in[1] = e1_ff[0] * e2_ff[2];
      pa_in[2] = e1_ff[0] * e2_ff[1];
      pb_in[2] = e1_ff[1] * e2_ff[0];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm4_in[i] = mag63(n3_ff[i]);
         wm4_in[i] = mag34(wv3_ff[i]);
      end
      nsh5_in = shift_of(nm4_ff[0] | nm4_ff[1] | nm4_ff[2]);
      wsh5_in = shift_of(63'(wm4_ff[0] | wm4_ff[1] | wm4_ff[2]));
      for (int i = 0; i < 3; i++) begin
         nsm6_in[i] = 30'(nm5_ff[i] >> nsh5_ff);
         wsm6_in[i] = 30'(wm5_ff[i] >> wsh5_ff);
      end
   end

   always_comb begin
      n2_in = 62'(nsq7_ff[0]) + 62'(nsq7_ff[1]) + 62'(nsq7_ff[2]);
      w2_in = 62'(wsq7_ff[0]) + 62'(wsq7_ff[1]) + 62'(wsq7_ff[2]);
      num_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (psg7_ff[i]) begin
            num_in = num_in - $signed(64'(pr7_ff[i]));
         end else begin
            num_in = num_in + $signed(64'(pr7_ff[i]));
         end
      end
      degen_in = nz7_ff && (n2_in <= tbc_pkg::EPS_SQ_MAX);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i]   <= e1_in[i];
            e2_ff[i]   <= e2_in[i];
            w1_ff[i]   <= w1_in[i];
            pa_ff[i]   <= pa_in[i];
            pb_ff[i]   <= pb_in[i];
            wv2_ff[i]  <= w1_ff[i];
            n3_ff[i]   <= pa_ff[i] - pb_ff[i];
            wv3_ff[i]  <= wv2_ff[i];
            nm4_ff[i]  <= nm4_in[i];
            wm4_ff[i]  <= wm4_in[i];
            nsg4_ff[i] <= n3_ff[i][63];
            wsg4_ff[i] <= wv3_ff[i][34];
            nm5_ff[i]  <= nm4_ff[i];
            wm5_ff[i]  <= wm4_ff[i];
            nsm6_ff[i] <= nsm6_in[i];
            wsm6_ff[i] <= wsm6_in[i];
            nsq7_ff[i] <= nsm6_ff[i] * nsm6_ff[i];
            wsq7_ff[i] <= wsm6_ff[i] * wsm6_ff[i];
            pr7_ff[i]  <= nsm6_ff[i] * wsm6_ff[i];
         end
         nsg5_ff  <= nsg4_ff;
         wsg5_ff  <= wsg4_ff;
         nsh5_ff  <= nsh5_in;
         wsh5_ff  <= wsh5_in;
         nsg6_ff  <= nsg5_ff;
         wsg6_ff  <= wsg5_ff;
         nz6_ff   <= (nsh5_ff == 6'd0);
         psg7_ff  <= nsg6_ff ^ wsg6_ff;
         nz7_ff   <= nz6_ff;
         n2_ff    <= n2_in;
         w2_ff    <= w2_in;
         num_ff   <= num_in;
         degen_ff <= degen_in;
      end
   end

   assign out_valid  = v_ff[7];
   assign n2         = n2_ff;
   assign w2         = w2_ff;
   assign side.degen = degen_ff;
   assign side.num   = num_ff;

endmodule

FILE: hdl/tbc_sqrt.sv
module tbc_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [61:0]          rad_a,
   input  logic [61:0]          rad_b,
   input  tbc_pkg::sq_side_type in_side,
   output logic                 out_valid,
   output logic [30:0]          root_a,
   output logic [30:0]          root_b,
   output tbc_pkg::sq_side_type out_side
);

   localparam int N = tbc_pkg::SQRT_STEPS;

   function automatic tbc_pkg::sqrt_lane_type sqrt_step(input tbc_pkg::sqrt_lane_type s);
      tbc_pkg::sqrt_lane_type o;
      logic [33:0] rs;
      logic [33:0] tr;
      rs = {s.rem[31:0], s.x[61:60]};
      tr = {1'b0, s.root, 2'b01};
      o.x = {s.x[59:0], 2'b00};
      if (rs >= tr) begin
         o.rem  = rs - tr;
         o.root = {s.root[29:0], 1'b1};
      end else begin
         o.rem  = rs;
         o.root = {s.root[29:0], 1'b0};
      end
      return o;
   endfunction

   logic [N-1:0]           v_ff;
   tbc_pkg::sqrt_lane_type a_ff [N];
   tbc_pkg::sqrt_lane_type b_ff [N];
   tbc_pkg::sq_side_type   s_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      tbc_pkg::sqrt_lane_type a_src, b_src;
      tbc_pkg::sq_side_type   s_src;
      if (k == 0) begin : g_first
         assign a_src = '{x: rad_a, rem: '0, root: '0};
         assign b_src = '{x: rad_b, rem: '0, root: '0};
         assign s_src = in_side;
      end else begin : g_next
         assign a_src = a_ff[k-1];
         assign b_src = b_ff[k-1];
         assign s_src = s_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[k] <= sqrt_step(a_src);
            b_ff[k] <= sqrt_step(b_src);
            s_ff[k] <= s_src;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign root_a    = a_ff[N-1].root;
   assign root_b    = b_ff[N-1].root;
   assign out_side  = s_ff[N-1];

endmodule

FILE: hdl/tbc_div.sv
module tbc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [30:0]          len_n,
   input  logic [30:0]          len_w,
   input  tbc_pkg::sq_side_type in_side,
   output logic                 out_valid,
   output logic signed [17:0]   dot,
   output logic                 degen
);

   localparam int N = tbc_pkg::DIV_STEPS;

   function automatic tbc_pkg::div_state_type div_step(input tbc_pkg::div_state_type s);
      tbc_pkg::div_state_type o;
      logic [62:0] r2;
      o  = s;
      r2 = {s.r[61:0], 1'b0};
      if (r2 >= 63'(s.den)) begin
         o.r = r2 - 63'(s.den);
         o.q = {s.q[14:0], 1'b1};
      end else begin
         o.r = r2;
         o.q = {s.q[14:0], 1'b0};
      end
      return o;
   endfunction

   logic [N+2:0]           v_ff;
   logic [61:0]            den_ff;
   logic [62:0]            mg_ff;
   logic signed [63:0]     neg_num;
   logic                   neg_ff, dga_ff;
   tbc_pkg::div_state_type init_in, init_ff;
   tbc_pkg::div_state_type st_ff [N];
   logic [16:0]            mag;
   logic signed [17:0]     dot_in, dot_ff;
   logic                   degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N+1:0], in_valid};
      end
   end

   assign neg_num = -in_side.num;

   always_comb begin
      init_in.den   = den_ff;
      init_in.r     = mg_ff;
      init_in.q     = '0;
      init_in.sat   = (mg_ff >= 63'(den_ff));
      init_in.zero  = (den_ff == '0);
      init_in.neg   = neg_ff;
      init_in.degen = dga_ff;
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      tbc_pkg::div_state_type src;
      if (k == 0) begin : g_first
         assign src = init_ff;
      end else begin : g_next
         assign src = st_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= div_step(src);
         end
      end
   end

   always_comb begin
      mag = st_ff[N-1].sat ? tbc_pkg::Q_ONE : {1'b0, st_ff[N-1].q};
      if (st_ff[N-1].zero || st_ff[N-1].degen) begin
         dot_in = '0;
      end else if (st_ff[N-1].neg) begin
         dot_in = -$signed({1'b0, mag});
      end else begin
         dot_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff   <= len_n * len_w;
         mg_ff    <= in_side.num[63] ? neg_num[62:0] : in_side.num[62:0];
         neg_ff   <= in_side.num[63];
         dga_ff   <= in_side.degen;
         init_ff  <= init_in;
         dot_ff   <= dot_in;
         degen_ff <= st_ff[N-1].degen;
      end
   end

   assign out_valid = v_ff[N+2];
   assign dot       = dot_ff;
   assign degen     = degen_ff;

endmodule

FILE: hdl/tbc_checker.sv
module tbc_props (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [tbc_pkg::RSP_W-1:0]     rsp_tdata
);

   logic signed [17:0] fd;
   assign fd = rsp_tdata[19:2];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_degen_cull: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0] && fd == 18'sd0)
      else $error("degenerate triangle not culled with zero dot");

   a_dot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fd <= 18'sd65536 && fd >= -18'sd65536 && rsp_tdata[23:20] == 4'd0)
      else $error("facing_dot out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind triangle_backface_cull_core tbc_props u_tbc_props (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
